>>> rtl/core/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("property failed");

`define ASSERT_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error("forbidden condition");

`else

`define ASSERT_PROP(lbl, ck, rs, prop)

`define ASSERT_NEVER(lbl, ck, rs, expr)

`endif

`endif

>>> rtl/core/ydl_pkg.sv
package ydl_pkg;

  localparam int CF_DEFAULT = 16;
  localparam int CF_MIN     = 8;
  localparam int T_MAX      = 3;
  localparam int SH_PAD     = T_MAX + 16 - CF_MIN;

  localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
  localparam logic [28:0] INV4PI_Q32 = 29'd341782638;
  localparam logic [38:0] XCAP       = 39'h40_0000_0000;
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

  // ceil(2^(32+l) / i) with 2^l >= i: exact floor division of 32-bit values
  function automatic logic [32:0] horner_magic(input logic [3:0] i);
    logic [32:0] m;
    case (i)
      4'd3, 4'd6, 4'd12: m = 33'h1_5555_5556;
      4'd5, 4'd10:       m = 33'h1_9999_999A;
      4'd7, 4'd14:       m = 33'h1_2492_4925;
      4'd9:              m = 33'h1_C71C_71C8;
      4'd11:             m = 33'h1_745D_1746;
      4'd13:             m = 33'h1_3B13_B13C;
      default:           m = 33'h1_0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] horner_shift(input logic [3:0] i);
    logic [5:0] s;
    case (i)
      4'd1:                     s = 6'd32;
      4'd2:                     s = 6'd33;
      4'd3, 4'd4:               s = 6'd34;
      4'd5, 4'd6, 4'd7, 4'd8:   s = 6'd35;
      default:                  s = 6'd36;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic               coinc;
    logic               neg;
    logic signed [6:0]  t;
    logic [62:0]        udot;
    logic [61:0]        s2;
    logic [63:0]        sv;
    logic [63:0]        sr;
    logic [31:0]        rn;
    logic [38:0]        x;
    logic [38:0]        xr;
    logic [6:0]         j;
    logic [31:0]        hv;
    logic [32:0]        acc;
    logic [32:0]        f;
    logic [63:0]        q;
  } ctx_t;

endpackage

>>> rtl/core/ydl_div.sv
module ydl_div
  import ydl_pkg::*;
#(
  parameter int DW = 62,
  parameter int QW = 65,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] num  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic [SW-1:0] side [0:QW];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rem;
  assign num[0]  = in_num;
  assign quo[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   rem_sh;
    logic          qbit;
    logic [DW-1:0] rem_next;

    always_comb begin
      rem_sh = {rem[k], num[k][QW-1]};
      qbit   = rem_sh >= {1'b0, den[k]};
      rem_next = qbit ? DW'(rem_sh - {1'b0, den[k]}) : rem_sh[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= rem_next;
      num[k+1]  <= num[k] << 1;
      quo[k+1]  <= {quo[k][QW-2:0], qbit};
      den[k+1]  <= den[k];
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule

>>> rtl/core/yukawa_double_layer_kernel.sv
// Yukawa double-layer kernel, fully pipelined: one point pair may be started
// in every cycle and its result appears with done, in order. The depth
// comes from two long divisions done one quotient bit per stage (65 and 64
// stages), a 32-stage square root and a 28-stage Horner evaluation of exp.
// busy is never raised and results cannot be held off.
`include "assert_macros.svh"

module yukawa_double_layer_kernel
  import ydl_pkg::*;
#(
  parameter int COORD_FRAC_BITS = CF_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] test_x,
  input  logic signed [31:0] test_y,
  input  logic signed [31:0] test_z,
  input  logic signed [31:0] trial_x,
  input  logic signed [31:0] trial_y,
  input  logic signed [31:0] trial_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  output logic               done,
  output logic signed [63:0] kernel_value,
  output logic               coincident,
  output logic               saturated
);

  logic [31:0] wave_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_number <= '0;
    end else if (cfg_we) begin
      wave_number <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // front end: difference, magnitude, normalization, products
  logic               v1, v2, v3, v4, v5, v6;
  logic signed [32:0] d1 [3];
  logic signed [31:0] n1 [3], n2 [3], n3 [3], n4 [3];
  logic [32:0]        a2 [3], a3 [3];
  logic               sg2 [3], sg3 [3];
  logic [32:0]        m2;
  logic signed [6:0]  t3, t4, t5;
  logic               c3, c4, c5;
  logic [29:0]        mg4 [3];
  logic signed [30:0] dn4 [3];
  logic [59:0]        sq5 [3];
  logic signed [62:0] pr5 [3];
  ctx_t               c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    d1[0] <= {trial_x[31], trial_x} - {test_x[31], test_x};
    d1[1] <= {trial_y[31], trial_y} - {test_y[31], test_y};
    d1[2] <= {trial_z[31], trial_z} - {test_z[31], test_z};
    n1[0] <= normal_x;
    n1[1] <= normal_y;
    n1[2] <= normal_z;
  end

  logic [32:0] a_c [3];
  logic [32:0] m_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_c[i] = d1[i][32] ? 33'(-d1[i]) : 33'(d1[i]);
    end
    m_c = a_c[0];
    if (a_c[1] > m_c) m_c = a_c[1];
    if (a_c[2] > m_c) m_c = a_c[2];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a2[i]  <= a_c[i];
      sg2[i] <= d1[i][32];
      n2[i]  <= n1[i];
    end
    m2 <= m_c;
  end

  logic [6:0] e_c;

  always_comb begin
    e_c = '0;
    for (int b = 0; b < 33; b++) begin
      if (m2[b]) e_c = 7'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    a3  <= a2;
    sg3 <= sg2;
    n3  <= n2;
    t3  <= $signed(e_c) - 7'sd30;
    c3  <= m2 == '0;
  end

  logic [29:0] mg_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (t3 > 0) begin
        mg_c[i] = 30'(a3[i] >> t3[5:0]);
      end else begin
        mg_c[i] = 30'(a3[i] << 6'(-t3));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mg4[i] <= mg_c[i];
      dn4[i] <= sg3[i] ? -$signed({1'b0, mg_c[i]}) : $signed({1'b0, mg_c[i]});
    end
    n4 <= n3;
    t4 <= t3;
    c4 <= c3;
  end

  logic signed [62:0] dx_c [3];
  logic signed [62:0] nx_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx_c[i] = 63'(dn4[i]);
      nx_c[i] = 63'(n4[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq5[i] <= 60'(60'(mg4[i]) * 60'(mg4[i]));
      pr5[i] <= dx_c[i] * nx_c[i];
    end
    t5 <= t4;
    c5 <= c4;
  end

  logic signed [63:0] dot_c;
  ctx_t               c6_next;

  always_comb begin
    dot_c = 64'(pr5[0]) + 64'(pr5[1]) + 64'(pr5[2]);
    c6_next       = '0;
    c6_next.coinc = c5;
    c6_next.t     = t5;
    c6_next.neg   = dot_c > 0;
    c6_next.udot  = dot_c[63] ? 63'(-dot_c) : dot_c[62:0];
    c6_next.s2    = 62'(sq5[0]) + 62'(sq5[1]) + 62'(sq5[2]);
    c6_next.sv    = 64'(c6_next.s2);
  end

  always_ff @(posedge clk) begin
    c6 <= c6_next;
  end

  // square root, one result bit per stage
  logic sqv [0:32];
  ctx_t sqc [0:32];

  assign sqv[0] = v6;
  assign sqc[0] = c6;

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    ctx_t nx;

    always_comb begin
      nx = sqc[k];
      if (nx.sv >= nx.sr + BIT) begin
        nx.sv = nx.sv - (nx.sr + BIT);
        nx.sr = (nx.sr >> 1) + BIT;
      end else begin
        nx.sr = nx.sr >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else begin
        sqv[k+1] <= sqv[k];
      end
    end

    always_ff @(posedge clk) begin
      sqc[k+1] <= nx;
    end
  end

  // k times r, scaled and clamped
  logic xav, xbv;
  ctx_t xac, xbc, xa_next, xb_next;
  logic [SH_PAD+63:0] xw_c;
  logic [5:0]         xamt_c;

  always_comb begin
    xa_next    = sqc[32];
    xa_next.rn = sqc[32].sr[31:0];
    xa_next.q  = 64'(wave_number) * 64'(sqc[32].sr[31:0]);
  end

  always_comb begin
    xamt_c = 6'(SH_PAD - (int'(xac.t) - COORD_FRAC_BITS + 16));
    xw_c   = {xac.q, SH_PAD'(0)} >> xamt_c;
    xb_next     = xac;
    xb_next.x   = (xw_c > (SH_PAD + 64)'(XCAP)) ? XCAP : xw_c[38:0];
    xb_next.xr  = xb_next.x;
    xb_next.j   = '0;
    xb_next.acc = ONE_Q32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xav <= 1'b0;
      xbv <= 1'b0;
    end else begin
      xav <= sqv[32];
      xbv <= xav;
    end
  end

  always_ff @(posedge clk) begin
    xac <= xa_next;
    xbc <= xb_next;
  end

  // x split into multiples of ln 2 and a remainder
  logic jv [0:7];
  ctx_t jc [0:7];

  assign jv[0] = xbv;
  assign jc[0] = xbc;

  for (genvar k = 0; k < 7; k++) begin : g_ln2
    localparam logic [38:0] STEP = 39'(LN2_Q32) << (6 - k);
    ctx_t nx;

    always_comb begin
      nx = jc[k];
      if (nx.xr >= STEP) begin
        nx.xr       = nx.xr - STEP;
        nx.j[6 - k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        jv[k+1] <= 1'b0;
      end else begin
        jv[k+1] <= jv[k];
      end
    end

    always_ff @(posedge clk) begin
      jc[k+1] <= nx;
    end
  end

  // exp(-rm) by Horner, two stages per term
  logic hv [0:28];
  ctx_t hc [0:28];

  assign hv[0] = jv[7];
  assign hc[0] = jc[7];

  for (genvar k = 0; k < 14; k++) begin : g_horner
    localparam logic [3:0] DIVR = 4'(14 - k);
    ctx_t        na, nb;
    logic [64:0] pa;
    logic [64:0] pb;

    always_comb begin
      na    = hc[2*k];
      pa    = 65'(na.xr[31:0]) * 65'(na.acc);
      na.hv = pa[63:32];
    end

    always_comb begin
      nb     = hc[2*k+1];
      pb     = (65'(nb.hv) * 65'(horner_magic(DIVR))) >> horner_shift(DIVR);
      nb.acc = ONE_Q32 - 33'(pb);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        hv[2*k+1] <= 1'b0;
        hv[2*k+2] <= 1'b0;
      end else begin
        hv[2*k+1] <= hv[2*k];
        hv[2*k+2] <= hv[2*k+1];
      end
    end

    always_ff @(posedge clk) begin
      hc[2*k+1] <= na;
      hc[2*k+2] <= nb;
    end
  end

  // f = (1 + x) exp(-x)
  logic        fav, fbv;
  ctx_t        fac, fbc, fb_next;
  logic [52:0] fpa;
  logic [51:0] fpb;
  logic [38:0] fy_c;
  logic [71:0] fprod_c, fsh_c;

  always_comb begin
    fy_c = 39'(ONE_Q32) + hc[28].x;
  end

  always_comb begin
    fprod_c = (72'(fpa) << 19) + 72'(fpb);
    fsh_c   = fprod_c >> (8'd32 + 8'(fac.j));
    fb_next   = fac;
    fb_next.f = (fsh_c > 72'(ONE_Q32)) ? ONE_Q32 : fsh_c[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fav <= 1'b0;
      fbv <= 1'b0;
    end else begin
      fav <= hv[28];
      fbv <= fav;
    end
  end

  always_ff @(posedge clk) begin
    fac <= hc[28];
    fpa <= 53'(hc[28].acc) * 53'(fy_c[38:19]);
    fpb <= 52'(hc[28].acc) * 52'(fy_c[18:0]);
    fbc <= fb_next;
  end

  // |dot| 2^60 / s2, then times 2^29 / r
  logic        q1v, q2v;
  logic [64:0] q1quo;
  logic [63:0] q2quo;
  logic [$bits(ctx_t)-1:0] q1side, q2side;
  ctx_t        q1c, q2c;

  ydl_div #(
    .DW(62),
    .QW(65),
    .SW($bits(ctx_t))
  ) u_div_s2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fbv),
    .in_rem   (62'(fbc.udot[62:5])),
    .in_num   ({fbc.udot[4:0], 60'd0}),
    .in_den   (fbc.s2),
    .in_side  (fbc),
    .out_valid(q1v),
    .out_quo  (q1quo),
    .out_side (q1side)
  );

  always_comb begin
    q1c   = ctx_t'(q1side);
    q1c.q = q1quo[64] ? '1 : q1quo[63:0];
  end

  ydl_div #(
    .DW(32),
    .QW(64),
    .SW($bits(ctx_t))
  ) u_div_r (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q1v),
    .in_rem   (32'(q1c.q[63:35])),
    .in_num   ({q1c.q[34:0], 29'd0}),
    .in_den   (q1c.rn),
    .in_side  (q1c),
    .out_valid(q2v),
    .out_quo  (q2quo),
    .out_side (q2side)
  );

  always_comb begin
    q2c   = ctx_t'(q2side);
    q2c.q = q2quo;
  end

  // times f, then times 1/(4 pi) with the final scaling
  logic        mav, mbv, cav, cbv;
  ctx_t        mac, mbc, cac, cbc, mb_next, cb_next;
  logic [64:0] mph, mpl;
  logic [60:0] cph, cpl;
  logic [97:0] msum_c;
  logic [93:0] csum_c, cshr_c;
  int          cs_c;

  always_comb begin
    msum_c    = 98'({mph, 32'd0}) + 98'(mpl);
    mb_next   = mac;
    mb_next.q = (msum_c[97:96] != 2'd0) ? '1 : msum_c[95:32];
  end

  always_comb begin
    cs_c = 119 + 2 * int'(cac.t) - 2 * COORD_FRAC_BITS;
    if (cs_c < 0) cs_c = 0;
    csum_c    = 94'({cph, 32'd0}) + 94'(cpl);
    cshr_c    = csum_c >> 7'(cs_c);
    cb_next   = cac;
    cb_next.q = (cshr_c[93:64] != '0) ? '1 : cshr_c[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mav  <= 1'b0;
      mbv  <= 1'b0;
      cav  <= 1'b0;
      cbv  <= 1'b0;
      done <= 1'b0;
    end else begin
      mav  <= q2v;
      mbv  <= mav;
      cav  <= mbv;
      cbv  <= cav;
      done <= cbv;
    end
  end

  always_ff @(posedge clk) begin
    mac <= q2c;
    mph <= 65'(q2c.q[63:32]) * 65'(q2c.f);
    mpl <= 65'(q2c.q[31:0]) * 65'(q2c.f);
    mbc <= mb_next;
    cac <= mbc;
    cph <= 61'(mbc.q[63:32]) * 61'(INV4PI_Q32);
    cpl <= 61'(mbc.q[31:0]) * 61'(INV4PI_Q32);
    cbc <= cb_next;
  end

  // sign, rails and coincident points
  logic signed [63:0] kv_c;
  logic               sat_c;

  always_comb begin
    sat_c = 1'b0;
    if (cbc.coinc) begin
      kv_c = '0;
    end else if (cbc.neg) begin
      if (cbc.q > 64'h8000_0000_0000_0000) begin
        kv_c  = 64'sh8000_0000_0000_0000;
        sat_c = 1'b1;
      end else begin
        kv_c = -$signed(cbc.q);
      end
    end else begin
      if (cbc.q[63]) begin
        kv_c  = 64'sh7FFF_FFFF_FFFF_FFFF;
        sat_c = 1'b1;
      end else begin
        kv_c = $signed(cbc.q);
      end
    end
  end

  always_ff @(posedge clk) begin
    kernel_value <= kv_c;
    coincident   <= cbc.coinc;
    saturated    <= sat_c;
  end

  `ASSERT_PROP(a_coinc_zero, clk, rst, done && coincident |-> kernel_value == '0 && !saturated)
  `ASSERT_PROP(a_sat_rail, clk, rst, done && saturated |-> kernel_value == 64'sh7FFF_FFFF_FFFF_FFFF || kernel_value == 64'sh8000_0000_0000_0000)

endmodule
